// ----- design/tslik_pkg.sv -----
// shared constants, types and tables of the two-servo leg solver
package tslik_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int SQRT_STEPS   = 32;
    localparam int CW           = 42;
    localparam int ZW           = 32;
    localparam int DEG          = 65536;
    localparam int N_STG        = 9 + SQRT_STEPS + 2 * CORDIC_STEPS;

    typedef logic signed [CW-1:0] t_cxy;
    typedef logic signed [ZW-1:0] t_ang;

    localparam t_ang ANG_45  = t_ang'(45 * DEG);
    localparam t_ang ANG_90  = t_ang'(90 * DEG);
    localparam t_ang ANG_135 = t_ang'(135 * DEG);
    localparam t_ang ANG_180 = t_ang'(180 * DEG);
    localparam t_ang ANG_360 = t_ang'(360 * DEG);

    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    // arctangent of 2^-i in 1/65536 degree
    localparam logic [22:0] ATAN_TAB [0:TAB_LEN-1] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
        23'd58666,   23'd29335,   23'd14668,  23'd7334,   23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115,    23'd57,     23'd29,
        23'd14,      23'd7,       23'd4,      23'd2,      23'd1,      23'd0
    };

    localparam logic [2:0] REG_A1 = 3'd0;
    localparam logic [2:0] REG_A2 = 3'd1;
    localparam logic [2:0] REG_B1 = 3'd2;
    localparam logic [2:0] REG_B2 = 3'd3;
    localparam logic [2:0] REG_BX = 3'd4;
    localparam logic [2:0] REG_BY = 3'd5;

    typedef struct packed {
        logic signed [22:0] n1;
        logic signed [22:0] n2;
        logic signed [22:0] n3;
        logic signed [10:0] x;
        logic signed [10:0] y;
        logic               fault;
    } t_sb_sqrt;

    typedef struct packed {
        t_cxy x;
        t_cxy y;
        t_ang z;
    } t_vin;

    typedef struct packed {
        t_ang ang;
        logic neg;
    } t_norm;

    typedef struct packed {
        logic signed [13:0] hip_o;
        logic signed [13:0] knee_o;
        logic               neg_h;
        logic               neg_k;
        logic               fault;
    } t_sb_rot;

endpackage

// ----- design/two_servo_leg_inverse_kinematics.sv -----
// top level of the two-servo leg inverse kinematics solver
// Takes one foot target (x, y in whole mm) per cycle and returns both servo angles
// (1/64 degree, clamped to +/-90) and the joint points (1/16 mm) of the leg. The
// pipeline is 9 + 32 + 2*CORDIC_STEPS stages deep: five stages of squares and
// products, a 32-stage square root, a vectoring cordic and a rotation cordic of
// CORDIC_STEPS stages each, plus quadrant fold, angle sum, normalize and output
// stages. A new item is taken every cycle; when the output item is not taken the
// whole pipeline holds. Configuration writes are registered, as are the squares and
// gain products derived from them, and should only be made while no item is in
// flight. An unreachable target or a zero radius sets the fault flag, zeroes the
// angles and places every joint at the origin.
module two_servo_leg_inverse_kinematics import tslik_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write port
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_index,
    input  logic [9:0]   i_cfg_wdata,
    // input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [23:0]  i_s_axis_tdata,   // target_x[10:0], target_y[21:11]
    // result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // hip_angle[13:0], knee_angle[27:14], hip_px[43:28], hip_py[59:44],
    // elbow_px[75:60], elbow_py[91:76], knee_px[107:92], knee_py[123:108],
    // foot_px[139:124], foot_py[155:140]
    output logic [159:0] o_m_axis_tdata,
    output logic [0:0]   o_m_axis_tuser    // reach_fault[0]
);

    // ---------------- configuration registers ----------------
    logic [8:0]  r_a1, r_a2, r_b1, r_b2;
    logic [9:0]  r_bx, r_by;
    logic [17:0] r_a1s, r_a2s, r_b1s, r_b2s;
    logic [38:0] r_a1g, r_a2g, r_b1g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1 <= 9'd75;
            r_a2 <= 9'd150;
            r_b1 <= 9'd150;
            r_b2 <= 9'd225;
            r_bx <= 10'd500;
            r_by <= 10'd800;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_A1:  r_a1 <= i_cfg_wdata[8:0];
                REG_A2:  r_a2 <= i_cfg_wdata[8:0];
                REG_B1:  r_b1 <= i_cfg_wdata[8:0];
                REG_B2:  r_b2 <= i_cfg_wdata[8:0];
                REG_BX:  r_bx <= i_cfg_wdata;
                REG_BY:  r_by <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // squares and cordic start lengths follow the config, not the items
    always_ff @(posedge i_clk) begin
        r_a1s <= 18'(r_a1) * 18'(r_a1);
        r_a2s <= 18'(r_a2) * 18'(r_a2);
        r_b1s <= 18'(r_b1) * 18'(r_b1);
        r_b2s <= 18'(r_b2) * 18'(r_b2);
        r_a1g <= 39'(r_a1) * 39'(GAIN_Q30);
        r_a2g <= 39'(r_a2) * 39'(GAIN_Q30);
        r_b1g <= 39'(r_b1) * 39'(GAIN_Q30);
    end

    // ---------------- flow control ----------------
    // one enable for the whole pipe: it moves unless the output item is stuck
    logic             w_en;
    logic [N_STG:1]   r_vld;

    assign w_en            = ~r_vld[N_STG] | i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[N_STG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N_STG-1:1], i_s_axis_tvalid};
        end
    end

    // ---------------- stage 1: target squares ----------------
    logic signed [10:0] w_tx, w_ty;
    logic signed [21:0] w_txe, w_tye, w_xx, w_yy;
    logic signed [10:0] r1_x, r1_y;
    logic [20:0]        r1_xx, r1_yy;

    assign w_tx  = i_s_axis_tdata[10:0];
    assign w_ty  = i_s_axis_tdata[21:11];
    assign w_txe = 22'(w_tx);
    assign w_tye = 22'(w_ty);
    assign w_xx  = w_txe * w_txe;
    assign w_yy  = w_tye * w_tye;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x  <= w_tx;
            r1_y  <= w_ty;
            r1_xx <= w_xx[20:0];
            r1_yy <= w_yy[20:0];
        end
    end

    // ---------------- stage 2: radius squared, fixed-link terms ----------------
    logic signed [10:0] r2_x, r2_y;
    logic [21:0]        r2_r2;
    logic [35:0]        r2_d2p, r2_d3p;
    logic signed [22:0] r2_n2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_r2  <= 22'(r1_xx) + 22'(r1_yy);
            r2_d2p <= 36'(r_a2s) * 36'(r_b1s);
            r2_d3p <= 36'(r_b1s) * 36'(r_b2s);
            r2_n2  <= $signed({5'd0, r_a2s}) + $signed({5'd0, r_b1s})
                    - $signed({5'd0, r_b2s});
        end
    end

    // ---------------- stage 3: cosine-law numerators ----------------
    logic signed [10:0] r3_x, r3_y;
    logic signed [22:0] r3_n1, r3_n2, r3_n3;
    logic [39:0]        r3_d1p;
    logic [35:0]        r3_d2p, r3_d3p;
    logic               r3_rz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_x   <= r2_x;
            r3_y   <= r2_y;
            r3_n1  <= $signed({5'd0, r_a1s}) + $signed({1'b0, r2_r2})
                    - $signed({5'd0, r_a2s});
            r3_n2  <= r2_n2;
            r3_n3  <= $signed({5'd0, r_b1s}) + $signed({5'd0, r_b2s})
                    - $signed({1'b0, r2_r2});
            r3_d1p <= 40'(r_a1s) * 40'(r2_r2);
            r3_d2p <= r2_d2p;
            r3_d3p <= r2_d3p;
            r3_rz  <= (r2_r2 == '0);
        end
    end

    // ---------------- stage 4: numerator squares ----------------
    logic signed [45:0] w_n1e, w_n2e, w_n3e, w_n1q, w_n2q, w_n3q;
    logic signed [10:0] r4_x, r4_y;
    logic signed [22:0] r4_n1, r4_n2, r4_n3;
    logic [47:0]        r4_q1, r4_q2, r4_q3, r4_d1, r4_d2, r4_d3;
    logic               r4_rz;

    assign w_n1e = 46'(r3_n1);
    assign w_n2e = 46'(r3_n2);
    assign w_n3e = 46'(r3_n3);
    assign w_n1q = w_n1e * w_n1e;
    assign w_n2q = w_n2e * w_n2e;
    assign w_n3q = w_n3e * w_n3e;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_x  <= r3_x;
            r4_y  <= r3_y;
            r4_n1 <= r3_n1;
            r4_n2 <= r3_n2;
            r4_n3 <= r3_n3;
            r4_q1 <= {2'b00, w_n1q};
            r4_q2 <= {2'b00, w_n2q};
            r4_q3 <= {2'b00, w_n3q};
            r4_d1 <= {6'd0, r3_d1p, 2'b00};
            r4_d2 <= {10'd0, r3_d2p, 2'b00};
            r4_d3 <= {10'd0, r3_d3p, 2'b00};
            r4_rz <= r3_rz;
        end
    end

    // ---------------- stage 5: reach test, square-root radicands ----------------
    logic [47:0] w_df1, w_df2, w_df3;
    logic [63:0] r5_rad1, r5_rad2, r5_rad3;
    t_sb_sqrt    r5_sb;

    assign w_df1 = r4_d1 - r4_q1;
    assign w_df2 = r4_d2 - r4_q2;
    assign w_df3 = r4_d3 - r4_q3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_rad1     <= {w_df1[43:0], 20'd0};
            r5_rad2     <= {w_df2[43:0], 20'd0};
            r5_rad3     <= {w_df3[43:0], 20'd0};
            r5_sb.n1    <= r4_n1;
            r5_sb.n2    <= r4_n2;
            r5_sb.n3    <= r4_n3;
            r5_sb.x     <= r4_x;
            r5_sb.y     <= r4_y;
            // unreachable when any acos argument leaves [-1, 1] or any denominator is zero
            r5_sb.fault <= r4_rz || (r4_d1 == '0) || (r4_d2 == '0) || (r4_d3 == '0)
                        || (r4_q1 > r4_d1) || (r4_q2 > r4_d2) || (r4_q3 > r4_d3);
        end
    end

    // ---------------- square roots, sine terms of the three acos ----------------
    logic [SQRT_STEPS-1:0] w_root1, w_root2, w_root3;
    t_sb_sqrt              r_sb1 [0:SQRT_STEPS-1];

    tslik_isqrt u_sqrt1 (.i_clk(i_clk), .i_en(w_en), .i_rad(r5_rad1), .o_root(w_root1));
    tslik_isqrt u_sqrt2 (.i_clk(i_clk), .i_en(w_en), .i_rad(r5_rad2), .o_root(w_root2));
    tslik_isqrt u_sqrt3 (.i_clk(i_clk), .i_en(w_en), .i_rad(r5_rad3), .o_root(w_root3));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb1[0] <= r5_sb;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_sb1[k] <= r_sb1[k-1];
            end
        end
    end

    // ---------------- quadrant fold ahead of the vectoring cordics ----------------
    function automatic t_vin f_prerot(t_cxy x, t_cxy y);
        t_vin v;
        if (x < 0) begin
            if (y >= 0) begin
                v.x = y;
                v.y = -x;
                v.z = ANG_90;
            end else begin
                v.x = -y;
                v.y = x;
                v.z = -ANG_90;
            end
        end else begin
            v.x = x;
            v.y = y;
            v.z = '0;
        end
        return v;
    endfunction

    t_sb_sqrt w_sb;
    t_vin     r_vin [0:3];
    logic     r_pre_fault;

    assign w_sb = r_sb1[SQRT_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vin[0]    <= f_prerot(CW'(w_sb.x) <<< 20, CW'(w_sb.y) <<< 20);
            r_vin[1]    <= f_prerot(CW'(w_sb.n1) <<< 10, CW'(w_root1));
            r_vin[2]    <= f_prerot(CW'(w_sb.n2) <<< 10, CW'(w_root2));
            r_vin[3]    <= f_prerot(CW'(w_sb.n3) <<< 10, CW'(w_root3));
            r_pre_fault <= w_sb.fault;
        end
    end

    // ---------------- vectoring cordics: atan2 of target and three acos ----------------
    t_ang w_vz [0:3];
    logic r_fd [0:CORDIC_STEPS-1];

    for (genvar v = 0; v < 4; v++) begin : g_vec
        t_cxy w_ox, w_oy;
        tslik_cordic u_vec (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_vec (1'b1),
            .i_x   (r_vin[v].x),
            .i_y   (r_vin[v].y),
            .i_z   (r_vin[v].z),
            .o_x   (w_ox),
            .o_y   (w_oy),
            .o_z   (w_vz[v])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fd[0] <= r_pre_fault;
            for (int k = 1; k < CORDIC_STEPS; k++) begin
                r_fd[k] <= r_fd[k-1];
            end
        end
    end

    // ---------------- servo angles ----------------
    t_ang r_hip, r_knee;
    logic r_sum_fault;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hip       <= w_vz[0] - w_vz[1] + ANG_45;
            r_knee      <= w_vz[2] + w_vz[3] - ANG_135;
            r_sum_fault <= r_fd[CORDIC_STEPS-1];
        end
    end

    // wrap to (-180, 180], then fold into [-90, 90] with a sign flip
    function automatic t_norm f_norm(t_ang a);
        t_norm n;
        n.ang = a;
        n.neg = 1'b0;
        if (n.ang > ANG_180) n.ang = n.ang - ANG_360;
        if (n.ang > ANG_180) n.ang = n.ang - ANG_360;
        if (n.ang <= -ANG_180) n.ang = n.ang + ANG_360;
        if (n.ang <= -ANG_180) n.ang = n.ang + ANG_360;
        if (n.ang > ANG_90) begin
            n.ang = n.ang - ANG_180;
            n.neg = 1'b1;
        end else if (n.ang < -ANG_90) begin
            n.ang = n.ang + ANG_180;
            n.neg = 1'b1;
        end
        return n;
    endfunction

    // round half up to 1/64 degree and clamp to +/-90
    function automatic logic signed [13:0] f_oang(t_ang u);
        t_ang v;
        v = (u + t_ang'(512)) >>> 10;
        if (v > t_ang'(5760)) v = t_ang'(5760);
        if (v < t_ang'(-5760)) v = t_ang'(-5760);
        return 14'(v);
    endfunction

    t_norm   w_hn, w_kn;
    t_norm   r_hn, r_kn;
    t_sb_rot r_nsb;

    assign w_hn = f_norm(r_hip);
    assign w_kn = f_norm(r_knee);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hn         <= w_hn;
            r_kn         <= w_kn;
            r_nsb.hip_o  <= f_oang(r_hip);
            r_nsb.knee_o <= f_oang(r_knee);
            r_nsb.neg_h  <= w_hn.neg;
            r_nsb.neg_k  <= w_kn.neg;
            r_nsb.fault  <= r_sum_fault;
        end
    end

    // ---------------- rotation cordics: link end offsets ----------------
    t_cxy    w_rx0 [0:2];
    t_ang    w_rz0 [0:2];
    t_cxy    w_rx  [0:2];
    t_cxy    w_ry  [0:2];
    t_sb_rot r_sb3 [0:CORDIC_STEPS-1];

    assign w_rx0[0] = CW'(r_a1g);
    assign w_rx0[1] = CW'(r_a2g);
    assign w_rx0[2] = CW'(r_b1g);
    assign w_rz0[0] = r_hn.ang;
    assign w_rz0[1] = r_hn.ang;
    assign w_rz0[2] = r_kn.ang;

    for (genvar p = 0; p < 3; p++) begin : g_rot
        t_ang w_oz;
        tslik_cordic u_rot (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_vec (1'b0),
            .i_x   (w_rx0[p]),
            .i_y   ('0),
            .i_z   (w_rz0[p]),
            .o_x   (w_rx[p]),
            .o_y   (w_ry[p]),
            .o_z   (w_oz)
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb3[0] <= r_nsb;
            for (int k = 1; k < CORDIC_STEPS; k++) begin
                r_sb3[k] <= r_sb3[k-1];
            end
        end
    end

    // ---------------- output stage ----------------
    // undo the fold, then round half up from q30 mm to 1/16 mm
    function automatic logic [15:0] f_rnd(t_cxy v, logic neg);
        t_cxy w;
        t_cxy s;
        w = neg ? -v : v;
        s = (w + t_cxy'(33554432)) >>> 26;
        return s[15:0];
    endfunction

    t_sb_rot     w_osb;
    logic [15:0] w_ox, w_oy;
    logic [15:0] w_ex, w_ey, w_kx, w_ky, w_fx, w_fy;
    logic [155:0] r_odata;
    logic         r_ofault;

    assign w_osb = r_sb3[CORDIC_STEPS-1];
    assign w_ox  = {2'b00, r_bx, 4'd0};
    assign w_oy  = {2'b00, r_by, 4'd0};
    assign w_ex  = w_ox + f_rnd(w_rx[0], w_osb.neg_h);
    assign w_ey  = w_oy + f_rnd(w_ry[0], w_osb.neg_h);
    assign w_kx  = w_ox + f_rnd(w_rx[1], w_osb.neg_h);
    assign w_ky  = w_oy + f_rnd(w_ry[1], w_osb.neg_h);
    assign w_fx  = w_kx + f_rnd(w_rx[2], w_osb.neg_k);
    assign w_fy  = w_ky + f_rnd(w_ry[2], w_osb.neg_k);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ofault <= w_osb.fault;
            if (w_osb.fault) begin
                // no solution: zero angles, every joint at the origin
                r_odata <= {w_oy, w_ox, w_oy, w_ox, w_oy, w_ox, w_oy, w_ox, 28'd0};
            end else begin
                r_odata <= {w_fy, w_fx, w_ky, w_kx, w_ey, w_ex, w_oy, w_ox,
                            w_osb.knee_o, w_osb.hip_o};
            end
        end
    end

    assign o_m_axis_tdata = {4'd0, r_odata};
    assign o_m_axis_tuser = r_ofault;

endmodule

// ----- design/tslik_isqrt.sv -----
// pipelined integer square root, one result bit per stage
module tslik_isqrt import tslik_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [SQRT_STEPS-1:0] o_root
);

    logic [63:0] r_v [0:SQRT_STEPS-2];
    logic [63:0] r_r [0:SQRT_STEPS-1];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - k));
        logic [63:0] w_vi;
        logic [63:0] w_ri;
        logic [63:0] w_t;
        logic        w_ge;

        if (k == 0) begin : g_first
            assign w_vi = i_rad;
            assign w_ri = '0;
        end else begin : g_next
            assign w_vi = r_v[k-1];
            assign w_ri = r_r[k-1];
        end

        assign w_t  = w_ri + BIT;
        assign w_ge = (w_vi >= w_t);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k] <= w_ge ? ((w_ri >> 1) + BIT) : (w_ri >> 1);
            end
        end

        if (k < SQRT_STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[k] <= w_ge ? (w_vi - w_t) : w_vi;
                end
            end
        end
    end

    assign o_root = r_r[SQRT_STEPS-1][SQRT_STEPS-1:0];

endmodule

// ----- design/tslik_cordic.sv -----
// pipelined cordic, vectoring or rotation, one micro-rotation per stage
module tslik_cordic import tslik_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  logic i_vec,
    input  t_cxy i_x,
    input  t_cxy i_y,
    input  t_ang i_z,
    output t_cxy o_x,
    output t_cxy o_y,
    output t_ang o_z
);

    t_cxy r_x [0:CORDIC_STEPS-1];
    t_cxy r_y [0:CORDIC_STEPS-1];
    t_ang r_z [0:CORDIC_STEPS-1];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        localparam t_ang STEP_ANG = t_ang'({{(ZW-23){1'b0}}, ATAN_TAB[k]});
        t_cxy w_xi;
        t_cxy w_yi;
        t_ang w_zi;
        logic w_up;

        if (k == 0) begin : g_first
            assign w_xi = i_x;
            assign w_yi = i_y;
            assign w_zi = i_z;
        end else begin : g_next
            assign w_xi = r_x[k-1];
            assign w_yi = r_y[k-1];
            assign w_zi = r_z[k-1];
        end

        // both modes share the same two directions
        assign w_up = i_vec ? ~w_yi[CW-1] : w_zi[ZW-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_up) begin
                    r_x[k] <= w_xi + (w_yi >>> k);
                    r_y[k] <= w_yi - (w_xi >>> k);
                    r_z[k] <= w_zi + STEP_ANG;
                end else begin
                    r_x[k] <= w_xi - (w_yi >>> k);
                    r_y[k] <= w_yi + (w_xi >>> k);
                    r_z[k] <= w_zi - STEP_ANG;
                end
            end
        end
    end

    assign o_x = r_x[CORDIC_STEPS-1];
    assign o_y = r_y[CORDIC_STEPS-1];
    assign o_z = r_z[CORDIC_STEPS-1];

endmodule

// ----- design/tslik_checker.sv -----
// port-level checks of the leg solver and their binding
module tslik_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_cfg_wr_en,
    input logic [2:0]   i_cfg_index,
    input logic [9:0]   i_cfg_wdata,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [23:0]  i_s_axis_tdata,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [159:0] o_m_axis_tdata,
    input logic [0:0]   o_m_axis_tuser
);

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[27:0] == 28'd0 && o_m_axis_tdata[75:60] == o_m_axis_tdata[43:28]
            && o_m_axis_tdata[155:140] == o_m_axis_tdata[59:44])
        else $error("fault result not at origin");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            $signed(o_m_axis_tdata[13:0]) <= 14'sd5760
            && $signed(o_m_axis_tdata[13:0]) >= -14'sd5760
            && $signed(o_m_axis_tdata[27:14]) <= 14'sd5760
            && $signed(o_m_axis_tdata[27:14]) >= -14'sd5760)
        else $error("servo angle beyond 90 degrees");

    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[31:28] == 4'd0 && o_m_axis_tdata[47:44] == 4'd0
            && o_m_axis_tdata[159:156] == 4'd0)
        else $error("origin not on a whole mm or pad bits set");

endmodule

bind two_servo_leg_inverse_kinematics tslik_checker u_tslik_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_wr_en     (i_cfg_wr_en),
    .i_cfg_index     (i_cfg_index),
    .i_cfg_wdata     (i_cfg_wdata),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
